### rtl/core/lfga_pkg.sv
// lowest free gate allocator: shared constants, widths and the command/status structs
// no dependencies; imported by every other file of the block but lfga_ram
`default_nettype none

package lfga_pkg;

    localparam int GATES      = 256;
    localparam int GATE_W     = (GATES > 1) ? $clog2(GATES) : 1;
    localparam int CNT_W      = $clog2(GATES + 1);
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 24;
    localparam int ENTRY_W    = TIME_W + COUNT_W;
    localparam int SUM_W      = COUNT_W + GATE_W + 1;
    localparam int TOTAL_W    = 25;
    localparam int CFG_W      = 9;
    localparam int GATE_NUM_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(256);

    localparam logic FUNC_PLACE  = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    typedef struct packed {
        logic clear;
        logic start;
        logic req_scan;
        logic sum_scan;
        logic walk_scan;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic done;
        logic clr_last;
    } sts_t;

endpackage

`default_nettype wire

### rtl/core/lfga_if.sv
// valid/ready channel interfaces for request beats and result beats
// depends on lfga_pkg for field widths
`default_nettype none

interface lfga_req_if import lfga_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic              class_sel;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] departure_time;

    modport source (output valid, func, class_sel, arrival_time, departure_time,
                    input ready);
    modport sink   (input valid, func, class_sel, arrival_time, departure_time,
                    output ready);
endinterface

interface lfga_res_if import lfga_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic [GATE_NUM_W-1:0] gate_number;
    logic [TOTAL_W-1:0]    best_total;

    modport source (output valid, accepted, gate_number, best_total, input ready);
    modport sink   (input valid, accepted, gate_number, best_total, output ready);
endinterface

`default_nettype wire

### rtl/core/lfga_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module lfga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/lfga_ctrl.sv
// sequencer: clearing pass, request scan, two-pass report walk, result hand-off
// depends on lfga_pkg for cmd_t and sts_t
`default_nettype none

module lfga_ctrl import lfga_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_func,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_REQ    = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;

    assign accept    = in_valid && (st_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        st_next        = st_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (st_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    st_next   = (in_func == FUNC_REPORT) ? ST_SUM : ST_REQ;
                end
            end
            ST_REQ:
            begin
                cmd.req_scan = 1'b1;
                if (sts.hit || sts.done)
                begin
                    st_next = ST_FINISH;
                end
            end
            ST_SUM:
            begin
                cmd.sum_scan = 1'b1;
                if (sts.done)
                begin
                    st_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk_scan = 1'b1;
                if (sts.done)
                begin
                    st_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (st_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/lfga_dp.sv
// datapath: per-class gate rams, scan counter, free test, prefix sums and result registers
// depends on lfga_pkg and lfga_ram
`default_nettype none

module lfga_dp import lfga_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  in_class_sel,
    input  wire logic [TIME_W-1:0]     in_arrival_time,
    input  wire logic [TIME_W-1:0]     in_departure_time,
    output logic                       out_accepted,
    output logic [GATE_NUM_W-1:0]      out_gate_number,
    output logic [TOTAL_W-1:0]         out_best_total
);

    logic [CFG_W-1:0]      cfg_reg, cfg_next;
    logic [CNT_W-1:0]      g_reg, g_next;
    logic                  pend_reg, pend_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic                  cls_reg, cls_next;
    logic [TIME_W-1:0]     arr_reg, arr_next;
    logic [TIME_W-1:0]     dep_reg, dep_next;
    logic [GATE_W-1:0]     idx_reg, idx_next;
    logic [SUM_W-1:0]      t_reg, t_next;
    logic [SUM_W-1:0]      best_reg, best_next;
    logic                  res_acc_reg, res_acc_next;
    logic [GATE_NUM_W-1:0] res_gate_reg, res_gate_next;
    logic [TOTAL_W-1:0]    res_best_reg, res_best_next;
    logic                  out_acc_reg, out_acc_next;
    logic [GATE_NUM_W-1:0] out_gate_reg, out_gate_next;
    logic [TOTAL_W-1:0]    out_best_reg, out_best_next;

    logic [CNT_W-1:0]      n_eff;
    logic                  scanning;
    logic                  g_end;
    logic                  issue;
    logic                  done;
    logic                  hit;
    logic [CNT_W-1:0]      g_back;
    logic [GATE_W-1:0]     ram0_raddr, ram1_raddr, waddr;
    logic [ENTRY_W-1:0]    ram0_q, ram1_q, sel_q, wdata;
    logic                  ram0_we, ram1_we;
    logic [TIME_W-1:0]     sel_busy;
    logic [COUNT_W-1:0]    sel_count, cnt_inc;
    logic [SUM_W-1:0]      c0_ext, c1_ext, t_walk, best_max;
    logic [TOTAL_W-1:0]    best_sat;

    // gate pools, one per class, entry is {busy_until, use_count}
    lfga_ram #(.WIDTH(ENTRY_W), .DEPTH(GATES)) u_ram0 (
        .clk   (clk),
        .we    (ram0_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ram0_raddr),
        .rdata (ram0_q)
    );

    lfga_ram #(.WIDTH(ENTRY_W), .DEPTH(GATES)) u_ram1 (
        .clk   (clk),
        .we    (ram1_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ram1_raddr),
        .rdata (ram1_q)
    );

    always_comb
    begin
        n_eff = ({{(32 - CFG_W){1'b0}}, cfg_reg} > 32'(GATES)) ? CNT_W'(GATES)
                                                                 : CNT_W'(cfg_reg);
        scanning = cmd.req_scan || cmd.sum_scan || cmd.walk_scan;
        g_end    = (g_reg == n_reg);
        issue    = scanning && !g_end;
        done     = g_end && !pend_reg;
        g_back   = n_reg - g_reg - CNT_W'(1);

        ram0_raddr = g_reg[GATE_W-1:0];
        ram1_raddr = cmd.walk_scan ? g_back[GATE_W-1:0] : g_reg[GATE_W-1:0];

        sel_q     = cls_reg ? ram1_q : ram0_q;
        sel_busy  = sel_q[ENTRY_W-1:COUNT_W];
        sel_count = sel_q[COUNT_W-1:0];
        cnt_inc   = (sel_count == COUNT_MAX) ? sel_count : sel_count + COUNT_W'(1);
        hit       = cmd.req_scan && pend_reg && (sel_busy <= arr_reg);

        ram0_we = cmd.clear || (hit && !cls_reg);
        ram1_we = cmd.clear || (hit && cls_reg);
        waddr   = cmd.clear ? g_reg[GATE_W-1:0] : idx_reg;
        wdata   = cmd.clear ? '0 : {dep_reg, cnt_inc};

        c0_ext   = SUM_W'(ram0_q[COUNT_W-1:0]);
        c1_ext   = SUM_W'(ram1_q[COUNT_W-1:0]);
        t_walk   = t_reg + c0_ext - c1_ext;
        best_max = (t_reg > best_reg) ? t_reg : best_reg;
        best_sat = (best_max > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : best_max[TOTAL_W-1:0];

        sts.hit      = hit;
        sts.done     = done;
        sts.clr_last = (g_reg == CNT_W'(GATES - 1));
    end

    always_comb
    begin
        cfg_next      = cfg_we ? cfg_wdata : cfg_reg;
        g_next        = g_reg;
        pend_next     = issue;
        idx_next      = g_reg[GATE_W-1:0];
        n_next        = n_reg;
        cls_next      = cls_reg;
        arr_next      = arr_reg;
        dep_next      = dep_reg;
        t_next        = t_reg;
        best_next     = best_reg;
        res_acc_next  = res_acc_reg;
        res_gate_next = res_gate_reg;
        res_best_next = res_best_reg;
        out_acc_next  = out_acc_reg;
        out_gate_next = out_gate_reg;
        out_best_next = out_best_reg;

        if (cmd.clear)
        begin
            g_next = g_reg + CNT_W'(1);
        end
        else if (cmd.start)
        begin
            g_next = '0;
        end
        else if (cmd.sum_scan && done)
        begin
            g_next = '0;
        end
        else if (issue)
        begin
            g_next = g_reg + CNT_W'(1);
        end

        if (cmd.start)
        begin
            n_next    = n_eff;
            cls_next  = in_class_sel;
            arr_next  = in_arrival_time;
            dep_next  = in_departure_time;
            t_next    = '0;
            best_next = '0;
        end

        if (cmd.sum_scan && pend_reg)
        begin
            t_next = t_reg + c1_ext;
        end

        if (cmd.walk_scan)
        begin
            best_next = best_max;
            if (pend_reg)
            begin
                t_next = t_walk;
            end
        end

        if (hit)
        begin
            res_acc_next  = 1'b1;
            res_gate_next = GATE_NUM_W'(32'(idx_reg) + 32'd1);
            res_best_next = '0;
        end
        else if (cmd.req_scan && done)
        begin
            res_acc_next  = 1'b0;
            res_gate_next = '0;
            res_best_next = '0;
        end
        else if (cmd.walk_scan && done)
        begin
            res_acc_next  = 1'b0;
            res_gate_next = '0;
            res_best_next = best_sat;
        end

        if (cmd.load_out)
        begin
            out_acc_next  = res_acc_reg;
            out_gate_next = res_gate_reg;
            out_best_next = res_best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= CFG_RESET;
            g_reg    <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            g_reg    <= g_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        cls_reg      <= cls_next;
        arr_reg      <= arr_next;
        dep_reg      <= dep_next;
        idx_reg      <= idx_next;
        t_reg        <= t_next;
        best_reg     <= best_next;
        res_acc_reg  <= res_acc_next;
        res_gate_reg <= res_gate_next;
        res_best_reg <= res_best_next;
        out_acc_reg  <= out_acc_next;
        out_gate_reg <= out_gate_next;
        out_best_reg <= out_best_next;
    end

    assign out_accepted    = out_acc_reg;
    assign out_gate_number = out_gate_reg;
    assign out_best_total  = out_best_reg;

endmodule

`default_nettype wire

### rtl/core/lowest_free_gate_allocator.sv
// top level of the lowest free gate allocator: sequencer plus datapath
// depends on lfga_pkg, lfga_if, lfga_ctrl and lfga_dp
//
//   channel  dir  handshake           payload
//   req      in   req.valid/ready     func, class_sel, arrival_time, departure_time
//   res      out  res.valid/ready     accepted, gate_number, best_total
//   cfg      in   cfg_we              cfg_wdata (gates_in_use)
//
// after reset a clearing pass over all GATES (256) entries zeroes both gate rams; no beat is
// taken meanwhile, cfg writes are. a place beat probes gates from gate 1 upward, one ram read
// a cycle, and takes the first free one or is rejected after n = min(gates_in_use, GATES);
// a report makes two passes over n gates, one summing class 1 and one walking both rams.
// one beat is in work at a time; a finished result sits in the output register, so the
// next beat is taken while res is stalled, and only its completion waits for the slot.
`default_nettype none

module lowest_free_gate_allocator import lfga_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    lfga_req_if.sink              req,
    lfga_res_if.source            res,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    lfga_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lfga_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_class_sel      (req.class_sel),
        .in_arrival_time   (req.arrival_time),
        .in_departure_time (req.departure_time),
        .out_accepted      (res.accepted),
        .out_gate_number   (res.gate_number),
        .out_best_total    (res.best_total)
    );

endmodule

`default_nettype wire

### test/lowest_free_gate_allocator_tb.sv
// testbench for lowest_free_gate_allocator: directed table then random phases over gate counts
// depends on lfga_pkg and lfga_if; results are checked against the row's typed value or a model of both gate pools
module lowest_free_gate_allocator_tb;
    import lfga_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic                  accepted;
        logic [GATE_NUM_W-1:0] gate_number;
        logic [TOTAL_W-1:0]    best_total;
    } gate_res_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              func;
        logic              class_sel;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] departure;
        logic              typed;
        gate_res_t         want;
    } stim_row_t;

    localparam gate_res_t NO_GATE = '0;
    localparam int        WATCHDOG_LIMIT = 20000;
    localparam int        SETTLE_CYCLES  = 8;
    localparam int        DRAIN_CYCLES   = 2 * GATES + 16;
    localparam int        HOLD_AT_BEAT   = 200;
    localparam int        HOLD_CYCLES    = 3000;
    localparam int        NUM_DIR        = 21;
    localparam int        NUM_PHASES     = 9;

    // cfg rows carry the gate count in the arrival field
    localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
        '{ROW_BEAT, FUNC_REPORT, 1'b0, 32'd0,         32'd0,         1'b1, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b0, 32'd0,         32'd10,        1'b1, '{1'b1, 9'd1, 25'd0}},
        '{ROW_BEAT, FUNC_PLACE,  1'b0, 32'd5,         32'd20,        1'b1, '{1'b1, 9'd2, 25'd0}},
        '{ROW_BEAT, FUNC_PLACE,  1'b1, 32'd0,         32'hFFFF_FFFF, 1'b1, '{1'b1, 9'd1, 25'd0}},
        '{ROW_BEAT, FUNC_PLACE,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b0, 32'd3,         32'd2,         1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b0, 32'd2,         32'd1,         1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_REPORT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_GATE},
        '{ROW_CFG,  FUNC_PLACE,  1'b0, 32'd0,         32'd0,         1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b0, 32'd7,         32'd8,         1'b1, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b1, 32'hFFFF_FFFF, 32'd0,         1'b1, NO_GATE},
        '{ROW_BEAT, FUNC_REPORT, 1'b0, 32'd0,         32'd0,         1'b1, NO_GATE},
        '{ROW_CFG,  FUNC_PLACE,  1'b0, 32'd1,         32'd0,         1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b0, 32'd100,       32'd200,       1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b0, 32'd150,       32'd300,       1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_REPORT, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NO_GATE},
        '{ROW_CFG,  FUNC_PLACE,  1'b0, 32'd511,       32'd0,         1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b1, 32'hFFFF_FFFF, 32'd5,         1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_PLACE,  1'b1, 32'd4,         32'd6,         1'b0, NO_GATE},
        '{ROW_BEAT, FUNC_REPORT, 1'b0, 32'd0,         32'd0,         1'b0, NO_GATE}
    };

    localparam logic [CFG_W-1:0] PHASE_GATES [NUM_PHASES] = '{
        9'd1, 9'd4, 9'd16, 9'd3, 9'd256, 9'd8, 9'd511, 9'd2, 9'd32
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lfga_req_if req_ch ();
    lfga_res_if res_ch ();

    lowest_free_gate_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [TIME_W-1:0]  busy_q [2][GATES];
    logic [COUNT_W-1:0] uses_q [2][GATES];
    logic [CFG_W-1:0]   gates_cfg = CFG_RESET;
    gate_res_t          pending_outcomes [$];
    int                 faults = 0;
    int                 outcomes_seen = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    initial
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int g = 0; g < GATES; g++)
            begin
                busy_q[c][g] = '0;
                uses_q[c][g] = '0;
            end
        end
    end

    function automatic gate_res_t gate_outcome(input logic func, input logic cls,
                                               input logic [TIME_W-1:0] arr,
                                               input logic [TIME_W-1:0] dep);
        gate_res_t r;
        int        n;
        longint    col0 [GATES+1];
        longint    col1 [GATES+1];
        longint    best;
        r = NO_GATE;
        n = (gates_cfg > GATES) ? GATES : int'(gates_cfg);
        if (func == FUNC_PLACE)
        begin
            for (int g = 0; g < n; g++)
            begin
                if (busy_q[cls][g] <= arr)
                begin
                    busy_q[cls][g] = dep;
                    if (uses_q[cls][g] != COUNT_MAX)
                        uses_q[cls][g] = uses_q[cls][g] + 1'b1;
                    r.accepted    = 1'b1;
                    r.gate_number = GATE_NUM_W'(g + 1);
                    break;
                end
            end
        end
        else
        begin
            col0[0] = 0;
            col1[0] = 0;
            for (int g = 0; g < n; g++)
            begin
                col0[g+1] = col0[g] + longint'(uses_q[0][g]);
                col1[g+1] = col1[g] + longint'(uses_q[1][g]);
            end
            best = 0;
            for (int i = 0; i <= n; i++)
                if (col0[i] + col1[n-i] > best)
                    best = col0[i] + col1[n-i];
            r.best_total = (best > longint'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(best);
        end
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] capped(input longint v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[TIME_W-1:0];
    endfunction

    task automatic offer_beat(input logic func, input logic cls,
                              input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] dep,
                              input logic typed, input gate_res_t want);
        gate_res_t pred;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.func           <= func;
        req_ch.class_sel      <= cls;
        req_ch.arrival_time   <= arr;
        req_ch.departure_time <= dep;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = gate_outcome(func, cls, arr, dep);
        pending_outcomes.push_back(typed ? want : pred);
    endtask

    task automatic set_gates(input logic [CFG_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gates_cfg = value;
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // stimulus
    initial
    begin
        logic [TIME_W-1:0] cursor [2];
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] dep;
        logic              cls;
        int                eff;
        int                pick;
        int                beats;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= FUNC_PLACE;
        req_ch.class_sel      <= 1'b0;
        req_ch.arrival_time   <= '0;
        req_ch.departure_time <= '0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        send_idle_pct = 37;
        recv_idle_pct = 61;
        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                set_gates(DIR_ROWS[i].arrival[CFG_W-1:0]);
            else
                offer_beat(DIR_ROWS[i].func, DIR_ROWS[i].class_sel, DIR_ROWS[i].arrival,
                           DIR_ROWS[i].departure, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        cursor[0] = 32'd1000;
        cursor[1] = 32'd1000;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_gates(PHASE_GATES[p]);
            if (p >= 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (p >= 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 37;
            end
            eff   = (PHASE_GATES[p] > GATES) ? GATES : int'(PHASE_GATES[p]);
            eff   = (eff == 0) ? 1 : eff;
            beats = (PHASE_GATES[p] >= GATES) ? 40 : 85;
            for (int c = 0; c < 2; c++)
                cursor[c] = capped(longint'(cursor[c]) + $urandom_range(0, 32'h1800_0000));
            for (int k = 0; k < beats; k++)
            begin
                pick = $urandom_range(0, 99);
                cls  = 1'($urandom_range(0, 1));
                if (pick < 8)
                begin
                    offer_beat(FUNC_REPORT, cls, $urandom(), $urandom(), 1'b0, NO_GATE);
                end
                else if (pick < 90)
                begin
                    arr = capped(longint'(cursor[cls]) + $urandom_range(0, 7));
                    cursor[cls] = arr;
                    dep = capped(longint'(arr) + $urandom_range(1, 12 * eff));
                    offer_beat(FUNC_PLACE, cls, arr, dep, 1'b0, NO_GATE);
                end
                else
                begin
                    // out of order arrival, departure mostly already past
                    arr = $urandom();
                    dep = ($urandom_range(0, 2) == 0) ? $urandom()
                                                      : $urandom_range(0, cursor[cls]);
                    offer_beat(FUNC_PLACE, cls, arr, dep, 1'b0, NO_GATE);
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0 && pending_outcomes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: checking and ready pattern
    initial
    begin
        gate_res_t got;
        gate_res_t want;
        int        hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.accepted, res_ch.gate_number, res_ch.best_total};
                outcomes_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    if (faults < 10)
                        $display("unexpected result beat: acc %0b gate %0d total %0d",
                                 got.accepted, got.gate_number, got.best_total);
                    faults++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got !== want)
                    begin
                        if (faults < 10)
                            $display("beat %0d: exp %0b/%0d/%0d, got %0b/%0d/%0d",
                                     outcomes_seen, want.accepted, want.gate_number,
                                     want.best_total, got.accepted, got.gate_number,
                                     got.best_total);
                        faults++;
                    end
                end
                if (outcomes_seen == HOLD_AT_BEAT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
